// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers of the base64 stream decoder
// Holds the job record passed from the front end to the back end, the depth
// of the job queue and the character classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // job queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // one job: up to three bytes, oldest in the high bits
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  count;   // number of result items, 1..3
        logic        has;     // 0 for a bare end mark
        logic        done;    // last item of the job closes the message
    } t_job;

    // classifier result
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // plain ASCII base64 alphabet; anything else (and '=') is not valid
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2F) begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character classifier and group builder
// Classifies each accepted character, gathers sextets into groups of four
// and turns a full group or a message end into one job for the back end.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_char,
    input  logic            i_eot,
    output logic            o_job_valid,
    output b64d_pkg::t_job  o_job
);
    import b64d_pkg::*;

    logic [17:0] r_store, n_store;
    logic [1:0]  r_fill,  n_fill;
    logic        r_halted, n_halted;

    t_sextet     sx;
    logic [17:0] st;
    logic [1:0]  fl;
    logic        hl;

    // decode step, then end-of-message flush
    always_comb begin
        sx          = sextet_of(i_char);
        st          = r_store;
        fl          = r_fill;
        hl          = r_halted;
        o_job_valid = 1'b0;
        o_job       = '{bytes: 24'd0, count: 2'd1, has: 1'b1, done: 1'b0};

        if (!r_halted) begin
            if (!sx.valid) begin
                hl = 1'b1;
            end else if (r_fill == 2'd3) begin
                o_job.bytes = {r_store, sx.value};
                o_job.count = 2'd3;
                o_job_valid = 1'b1;
                st          = 18'd0;
                fl          = 2'd0;
            end else begin
                st = {r_store[11:0], sx.value};
                fl = r_fill + 2'd1;
            end
        end

        if (i_eot) begin
            o_job.done  = 1'b1;
            o_job_valid = 1'b1;
            if (fl == 2'd2) begin
                o_job.bytes = {st[11:4], 16'd0};
                o_job.count = 2'd1;
            end else if (fl == 2'd3) begin
                o_job.bytes = {st[17:10], st[9:2], 8'd0};
                o_job.count = 2'd2;
            end else if (!(o_job.count == 2'd3 && !r_halted && sx.valid)) begin
                // nothing left: bare end mark
                o_job.bytes = 24'd0;
                o_job.count = 2'd1;
                o_job.has   = 1'b0;
            end
        end

        n_store  = r_store;
        n_fill   = r_fill;
        n_halted = r_halted;
        if (i_accept) begin
            if (i_eot) begin
                n_store  = 18'd0;
                n_fill   = 2'd0;
                n_halted = 1'b0;
            end else begin
                n_store  = st;
                n_fill   = fl;
                n_halted = hl;
            end
        end
    end

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= 18'd0;
            r_fill   <= 2'd0;
            r_halted <= 1'b0;
        end else begin
            r_store  <= n_store;
            r_fill   <= n_fill;
            r_halted <= n_halted;
        end
    end

endmodule

// File: rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: job queue between front and back end
// Small register FIFO; the head entry is visible while empty is low.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output b64d_pkg::t_job  o_job
);
    import b64d_pkg::*;

    t_job          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: job serializer and result register
// Takes one job from the queue and hands out its bytes one item per cycle
// while the receiver pops, through a registered result stage.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  b64d_pkg::t_job  i_q_job,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_data_byte,
    output logic            o_has_byte,
    output logic            o_message_done
);
    import b64d_pkg::*;

    t_job       r_job;
    logic       r_job_valid;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic       r_done;

    logic       out_load, advance, job_last, job_load;
    logic [7:0] sel_byte;

    // serializer control
    assign out_load = !r_out_valid || i_pop;
    assign advance  = out_load && r_job_valid;
    assign job_last = (r_idx == (r_job.count - 2'd1));
    assign job_load = !r_job_valid || (advance && job_last);
    assign o_q_pop  = job_load && !i_q_empty;

    // pick the current byte, oldest first
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = r_job.bytes[23:16];
            2'd1:    sel_byte = r_job.bytes[15:8];
            default: sel_byte = r_job.bytes[7:0];
        endcase
    end

    // job holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (job_load) begin
            r_job_valid <= !i_q_empty;
            r_idx       <= 2'd0;
        end else if (advance) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= sel_byte;
            r_has  <= r_job.has;
            r_done <= r_job.done && job_last;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_data_byte    = r_byte;
    assign o_has_byte     = r_has;
    assign o_message_done = r_done;

endmodule

// File: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 text decoder
// Input side: one ASCII character per item, with an end-of-text flag. An
// item is taken when push is high and full is low.
// Result side: one decoded byte per item, or a bare end mark (has_byte 0).
// The oldest result is on the ports while empty is low and leaves when
// pop is high.
// A full group of four characters gives three results; the message end
// flushes a partial group and always ends with a result carrying
// message_done. Invalid characters and '=' stop decoding until the end.
// A result passes the job queue, job holding register and result register.
// Throughput: one character per cycle in; the back end hands out one result
// per cycle while pop is high, so a stream of full groups runs at one
// character per cycle. A four-entry job queue decouples the two sides; when
// the receiver stalls, the queue fills and full rises. Reset (synchronous,
// active low) clears the group state, the queue and the result register.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic       o_has_byte,
    output logic       o_message_done
);
    import b64d_pkg::*;

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job head_job;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    // front end: classify and group
    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char      (i_char_in),
        .i_eot       (i_end_of_text),
        .o_job_valid (job_valid),
        .o_job       (front_job)
    );

    // job queue
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && job_valid),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // back end: serialize bytes
    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_job        (head_job),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_data_byte    (o_data_byte),
        .o_has_byte     (o_has_byte),
        .o_message_done (o_message_done)
    );

endmodule
